// ===== hw/rtl/stack_machine_instruction_executor_assert.svh =====
// Assertion macros shared by the checker
`ifndef STACK_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH

// implication check, active out of reset
`define SMX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smx check failed");

// next-cycle implication check
`define SMX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smx check failed");

`endif

// ===== hw/rtl/smx_pkg.sv =====
package smx_pkg;

    localparam int MEM_DEPTH  = 512;
    localparam int DATA_WIDTH = 32;
    localparam int PC_WIDTH   = 16;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int SW         = AW + 1;

    localparam logic [AW-1:0] RESET_TOP = AW'(499);
    localparam int INSTR_WORDS = 3;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [SW-1:0] sidx_t;
    typedef logic [PC_WIDTH-1:0] pc_t;

    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_SYS = 4'd9;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_BADOP = 3'd2;
    localparam logic [2:0] ST_BADOPR = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_RANGE = 3'd5;

    // divider request/response
    typedef struct packed {
        logic  start;
        word_t num;
        word_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quo;
    } div_rsp_t;

endpackage

// ===== hw/rtl/smx_ram.sv =====
module smx_ram
    import smx_pkg::*;
(
    input  logic  clk,
    input  logic  we,
    input  addr_t waddr,
    input  word_t wdata,
    input  addr_t raddr,
    output word_t rdata
);

    word_t mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/smx_div.sv =====
module smx_div
    import smx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    word_t          quo_reg, quo_next;
    word_t          rem_reg, rem_next;
    word_t          den_reg, den_next;
    logic           neg_reg, neg_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DATA_WIDTH:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        trial     = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num[DATA_WIDTH-1] ? (~req.num + 1'b1) : req.num;
            den_next  = req.den[DATA_WIDTH-1] ? (~req.den + 1'b1) : req.den;
            neg_next  = req.num[DATA_WIDTH-1] ^ req.den[DATA_WIDTH-1];
            rem_next  = '0;
            cnt_next  = CW'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_WIDTH])
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== hw/rtl/stack_machine_instruction_executor.sv =====
// channel    | signals                                        | dir
// cfg        | cfg_valid/cfg_ready, cfg_data                  | in
// in         | in_valid/in_ready, cmd, level, modifier, read_value | in
// out        | out_valid/out_ready, next_pc .. status         | out
// Each load walk step, each operand read and each write of a request goes
// through the data memory, one read port and one write port; DIV also waits
// for the divider. After reset a clearing pass zeroes the 512 data words;
// no request is taken until it ends. Results wait in the output register;
// the next request is taken once the result is delivered.
module stack_machine_instruction_executor
    import smx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  cmd,
    input  logic [3:0]  level,
    input  logic signed [31:0] modifier,
    input  logic signed [31:0] read_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_pc,
    output logic [8:0]  base_pointer,
    output logic [9:0]  stack_pointer,
    output logic        write_valid,
    output logic signed [31:0] write_value,
    output logic        halted,
    output logic [2:0]  status
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_RD1   = 4'd4;
    localparam logic [3:0] S_RD2   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_WR2   = 4'd8;
    localparam logic [3:0] S_WR3   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_WALKW = 4'd12;

    localparam logic [SW:0] DEPTH_X = (SW+1)'(MEM_DEPTH);

    logic [3:0]  st_reg, st_next;
    addr_t       clr_reg, clr_next;
    pc_t         pc_reg, pc_next;
    addr_t       bp_reg, bp_next;
    sidx_t       sp_reg, sp_next;
    logic        stop_reg, stop_next;
    logic [2:0]  stat_reg, stat_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [3:0]  lev_reg, lev_next;
    word_t       mod_reg, mod_next;
    word_t       rv_reg, rv_next;
    addr_t       t_reg, t_next;
    word_t       x_reg, x_next;
    word_t       y_reg, y_next;
    word_t       r_reg, r_next;
    logic        ov_reg, ov_next;
    logic        wv_reg, wv_next;
    word_t       wval_reg, wval_next;

    logic        we;
    addr_t       waddr, raddr;
    word_t       wdata, rdata;
    div_req_t    dreq;
    div_rsp_t    drsp;

    smx_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);
    smx_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

    // signed views, wide enough for range checks
    logic signed [DATA_WIDTH+SW+1:0] m_s, sp_s, bp_s, t_s;
    logic signed [DATA_WIDTH+SW+1:0] addr_m;
    logic [4:0]  opr;
    logic        opr_ok;
    logic        word_ok;
    logic        lt_xy, lt_yx;

    always_comb
    begin
        m_s    = (DATA_WIDTH+SW+2)'(signed'(mod_reg));
        sp_s   = (DATA_WIDTH+SW+2)'(signed'({1'b0, sp_reg}));
        bp_s   = (DATA_WIDTH+SW+2)'(signed'({2'b0, bp_reg}));
        t_s    = (DATA_WIDTH+SW+2)'(signed'({2'b0, t_reg}));
        addr_m = t_s - m_s;
        opr_ok = (mod_reg[DATA_WIDTH-1:4] == '0) && (mod_reg[3:0] <= 4'd11);
        opr    = {1'b0, mod_reg[3:0]};
        word_ok = !rdata[DATA_WIDTH-1] && (rdata < word_t'(MEM_DEPTH));
        lt_xy  = signed'(x_reg) < signed'(y_reg);
        lt_yx  = signed'(y_reg) < signed'(x_reg);
    end

    function automatic logic in_st(input logic signed [DATA_WIDTH+SW+1:0] a);
        in_st = (a >= 0) && (a < MEM_DEPTH);
    endfunction

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        pc_next   = pc_reg;
        bp_next   = bp_reg;
        sp_next   = sp_reg;
        stop_next = stop_reg;
        stat_next = stat_reg;
        cmd_next  = cmd_reg;
        lev_next  = lev_reg;
        mod_next  = mod_reg;
        rv_next   = rv_reg;
        t_next    = t_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        ov_next   = ov_reg;
        wv_next   = wv_reg;
        wval_next = wval_reg;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        raddr     = '0;
        dreq      = '{start: 1'b0, num: x_reg, den: y_reg};

        if (cfg_valid && cfg_ready)
        begin
            bp_next = cfg_data;
            sp_next = SW'(cfg_data) + 1'b1;
        end

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == addr_t'(MEM_DEPTH - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd_next = cmd;
                    lev_next = level;
                    mod_next = modifier;
                    rv_next  = read_value;
                    wv_next  = 1'b0;
                    wval_next = '0;
                    t_next   = bp_reg;
                    st_next  = stop_reg ? S_OUT : S_DEC;
                end
            end
            S_DEC:
            begin
                pc_next = pc_reg;
                case (cmd_reg)
                    OP_LIT:
                    begin
                        if (!in_st(sp_s - 1)) stat_next = ST_RANGE;
                        else
                        begin
                            we = 1'b1; waddr = addr_t'(sp_reg - 1'b1); wdata = mod_reg;
                            sp_next = sp_reg - 1'b1;
                        end
                        st_next = S_DONE;
                    end
                    OP_OPR:
                    begin
                        if (!opr_ok)
                        begin
                            stat_next = ST_BADOPR; st_next = S_DONE;
                        end
                        else if (opr == 5'd0)
                        begin
                            if (!in_st(bp_s - 1) || !in_st(bp_s - 2))
                            begin
                                stat_next = ST_RANGE; st_next = S_DONE;
                            end
                            else
                            begin
                                raddr = addr_t'(bp_reg - 1'b1); st_next = S_RD1;
                            end
                        end
                        else if (opr == 5'd11)
                        begin
                            if (!in_st(sp_s))
                            begin
                                stat_next = ST_RANGE; st_next = S_DONE;
                            end
                            else
                            begin
                                raddr = addr_t'(sp_reg); st_next = S_RD1;
                            end
                        end
                        else
                        begin
                            if (!in_st(sp_s) || !in_st(sp_s + 1))
                            begin
                                stat_next = ST_RANGE; st_next = S_DONE;
                            end
                            else
                            begin
                                raddr = addr_t'(sp_reg); st_next = S_RD1;
                            end
                        end
                    end
                    OP_LOD, OP_STO, OP_CAL:
                    begin
                        if (!in_st(bp_s))
                        begin
                            stat_next = ST_RANGE; st_next = S_DONE;
                        end
                        else if (lev_reg != 4'd0)
                        begin
                            raddr = t_reg; st_next = S_WALK;
                        end
                        else
                        begin
                            st_next = S_WALKW;
                        end
                    end
                    OP_INC:
                    begin
                        if ((sp_s - m_s) < 0 || (sp_s - m_s) > MEM_DEPTH)
                            stat_next = ST_RANGE;
                        else
                            sp_next = SW'(sp_s - m_s);
                        st_next = S_DONE;
                    end
                    OP_JMP:
                    begin
                        st_next = S_DONE;
                    end
                    OP_JPC:
                    begin
                        if (!in_st(sp_s))
                        begin
                            stat_next = ST_RANGE; st_next = S_DONE;
                        end
                        else
                        begin
                            raddr = addr_t'(sp_reg); st_next = S_RD1;
                        end
                    end
                    OP_SYS:
                    begin
                        st_next = S_DONE;
                        if (mod_reg == word_t'(1))
                        begin
                            if (!in_st(sp_s))
                                stat_next = ST_RANGE;
                            else
                            begin
                                raddr = addr_t'(sp_reg); st_next = S_RD1;
                            end
                        end
                        else if (mod_reg == word_t'(2))
                        begin
                            if (!in_st(sp_s - 1)) stat_next = ST_RANGE;
                            else
                            begin
                                we = 1'b1; waddr = addr_t'(sp_reg - 1'b1); wdata = rv_reg;
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        stat_next = ST_BADOP; st_next = S_DONE;
                    end
                endcase
            end
            S_WALK:
            begin
                // rdata holds the link at t_reg
                st_next = S_WALK;
                if (!word_ok)
                begin
                    stat_next = ST_RANGE; st_next = S_DONE;
                end
                else
                begin
                    t_next   = addr_t'(rdata);
                    lev_next = lev_reg - 1'b1;
                    raddr    = addr_t'(rdata);
                    if (lev_reg == 4'd1) st_next = S_WALKW;
                end
            end
            S_WALKW:
            begin
                // address checks once the frame base t_reg is known
                st_next = S_DONE;
                if (cmd_reg == OP_LOD)
                begin
                    if (!in_st(addr_m) || !in_st(sp_s - 1)) stat_next = ST_RANGE;
                    else
                    begin
                        raddr = addr_t'(addr_m); st_next = S_RD1;
                    end
                end
                else if (cmd_reg == OP_STO)
                begin
                    if (!in_st(addr_m) || !in_st(sp_s)) stat_next = ST_RANGE;
                    else
                    begin
                        raddr = addr_t'(sp_reg); st_next = S_RD1;
                    end
                end
                else
                begin
                    if (!in_st(sp_s - 1) || !in_st(sp_s - 3)) stat_next = ST_RANGE;
                    else
                    begin
                        we = 1'b1; waddr = addr_t'(sp_reg - 1'b1);
                        wdata = word_t'(t_reg);
                        st_next = S_WR2;
                    end
                end
            end
            S_WR2:
            begin
                we = 1'b1; waddr = addr_t'(sp_reg - 2'd2); wdata = word_t'(bp_reg);
                st_next = S_WR3;
            end
            S_WR3:
            begin
                we = 1'b1; waddr = addr_t'(sp_reg - 2'd3);
                wdata = word_t'(pc_t'(pc_reg + pc_t'(INSTR_WORDS)));
                bp_next = addr_t'(sp_reg - 1'b1);
                pc_next = pc_t'(mod_reg);
                st_next = S_OUT;
            end
            S_RD1:
            begin
                x_next = rdata;
                st_next = S_DONE;
                case (cmd_reg)
                    OP_LOD:
                    begin
                        we = 1'b1; waddr = addr_t'(sp_reg - 1'b1); wdata = rdata;
                        sp_next = sp_reg - 1'b1;
                    end
                    OP_STO:
                    begin
                        we = 1'b1; waddr = addr_t'(addr_m); wdata = rdata;
                        sp_next = sp_reg + 1'b1;
                    end
                    OP_JPC:
                    begin
                        sp_next = sp_reg + 1'b1;
                        pc_next = (rdata == '0) ? pc_t'(mod_reg)
                                                : pc_t'(pc_reg + pc_t'(INSTR_WORDS));
                        st_next = S_OUT;
                    end
                    OP_SYS:
                    begin
                        wv_next = 1'b1; wval_next = rdata;
                        sp_next = sp_reg + 1'b1;
                    end
                    default:
                    begin
                        if (opr == 5'd0)
                        begin
                            if (!word_ok)
                                stat_next = ST_RANGE;
                            else
                            begin
                                t_next = addr_t'(rdata);
                                raddr = addr_t'(bp_reg - 2'd2);
                                st_next = S_RD2;
                            end
                        end
                        else if (opr == 5'd11)
                        begin
                            we = 1'b1; waddr = addr_t'(sp_reg);
                            wdata = word_t'(rdata[0]);
                        end
                        else
                        begin
                            y_next = rdata;
                            raddr = addr_t'(sp_reg + 1'b1);
                            st_next = S_RD2;
                        end
                    end
                endcase
            end
            S_RD2:
            begin
                if (opr == 5'd0)
                begin
                    pc_next = pc_t'(rdata);
                    sp_next = SW'(bp_reg) + 1'b1;
                    bp_next = t_reg;
                    st_next = S_OUT;
                end
                else
                begin
                    x_next = rdata;
                    st_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next = S_DONE;
                case (opr)
                    5'd1: r_next = x_reg + y_reg;
                    5'd2: r_next = x_reg - y_reg;
                    5'd3: r_next = x_reg * y_reg;
                    5'd5: r_next = word_t'(x_reg == y_reg);
                    5'd6: r_next = word_t'(x_reg != y_reg);
                    5'd7: r_next = word_t'(lt_xy);
                    5'd8: r_next = word_t'(!lt_yx);
                    5'd9: r_next = word_t'(lt_yx);
                    5'd10: r_next = word_t'(!lt_xy);
                    default:
                    begin
                        if (y_reg == '0)
                            stat_next = ST_DIV0;
                        else
                        begin
                            dreq.start = 1'b1; st_next = S_DIV;
                        end
                    end
                endcase
                if (opr != 5'd4)
                begin
                    st_next = S_WR2 + 4'd0;
                    st_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (opr != 5'd4 || drsp.done)
                begin
                    we = 1'b1; waddr = addr_t'(sp_reg + 1'b1);
                    wdata = (opr == 5'd4) ? drsp.quo : r_reg;
                    sp_next = sp_reg + 1'b1;
                    st_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat_next != ST_OK && stat_next != stat_reg)
                begin
                    stop_next = 1'b1;
                end
                else if (stat_reg == ST_OK)
                begin
                    pc_next = pc_t'(pc_reg + pc_t'(INSTR_WORDS));
                    if (cmd_reg == OP_JMP) pc_next = pc_t'(mod_reg);
                    if (cmd_reg == OP_SYS && mod_reg == word_t'(3))
                    begin
                        stop_next = 1'b1; stat_next = ST_HALT;
                    end
                end
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (stop_next && stat_reg != ST_HALT && stat_reg != ST_OK)
                begin
                    wv_next = 1'b0; wval_next = '0;
                end
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // a fault raised before S_DONE stops the machine now and skips to S_OUT
        if (st_reg != S_CLR && st_reg != S_IDLE && st_reg != S_DONE && st_reg != S_OUT
            && stat_next != stat_reg && !stop_reg)
        begin
            stop_next = 1'b1;
            st_next   = S_OUT;
            we        = 1'b0;
            sp_next   = sp_reg;
            bp_next   = bp_reg;
            pc_next   = pc_reg;
            wv_next   = 1'b0;
            wval_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLR;
            clr_reg  <= '0;
            pc_reg   <= '0;
            bp_reg   <= RESET_TOP;
            sp_reg   <= SW'(RESET_TOP) + 1'b1;
            stop_reg <= 1'b0;
            stat_reg <= ST_OK;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            pc_reg   <= pc_next;
            bp_reg   <= bp_next;
            sp_reg   <= sp_next;
            stop_reg <= stop_next;
            stat_reg <= stat_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        lev_reg  <= lev_next;
        mod_reg  <= mod_next;
        rv_reg   <= rv_next;
        t_reg    <= t_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        r_reg    <= r_next;
        wv_reg   <= wv_next;
        wval_reg <= wval_next;
    end

    assign cfg_ready     = (st_reg == S_IDLE) || (st_reg == S_CLR);
    assign in_ready      = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid     = ov_reg;
    assign next_pc       = pc_reg;
    assign base_pointer  = bp_reg;
    assign stack_pointer = sp_reg;
    assign write_valid   = wv_reg;
    assign write_value   = wval_reg;
    assign halted        = stop_reg;
    assign status        = stat_reg;

    logic unused_ok;
    assign unused_ok = ^DEPTH_X;

endmodule

// ===== hw/rtl/smx_checker.sv =====
`include "stack_machine_instruction_executor_assert.svh"

module smx_checker
    import smx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        write_valid,
    input logic        halted,
    input logic [2:0]  status,
    input logic [9:0]  stack_pointer
);

    // a request is taken only while no result is pending
    `SMX_ASSERT_IMP(a_no_overlap, in_valid && in_ready, !out_valid)
    // stopped machine never clears its stop
    `SMX_ASSERT_NXT(a_stop_sticky, halted, halted)
    // a nonzero status goes with the stop flag
    `SMX_ASSERT_IMP(a_stat_halt, out_valid && status != ST_OK, halted)
    // no emitted word on a fault
    `SMX_ASSERT_IMP(a_wv_fault, out_valid && write_valid, status == ST_OK || status == ST_HALT)
    // stack pointer bounded by the store depth
    `SMX_ASSERT_IMP(a_sp_range, out_valid, stack_pointer <= 10'(MEM_DEPTH))

endmodule

bind stack_machine_instruction_executor smx_checker u_smx_checker (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .write_valid, .halted, .status, .stack_pointer
);

// ===== verif/tb_top.sv =====
module tb_top;
    import smx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]  cmd;
        logic [3:0]  level;
        logic [31:0] modifier;
        logic [31:0] read_value;
    } instr_t;

    typedef struct {
        logic [15:0] next_pc;
        logic [8:0]  base_pointer;
        logic [9:0]  stack_pointer;
        logic        write_valid;
        logic [31:0] write_value;
        logic        halted;
        logic [2:0]  status;
    } vm_state_t;

    localparam int OPR_RET = 0;
    localparam int OPR_DIV = 4;
    localparam int OPR_ODD = 11;
    localparam int SYS_WRITE = 1;
    localparam int SYS_READ = 2;
    localparam int SYS_HALT = 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [8:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] cmd = '0;
    logic [3:0] level = '0;
    logic signed [31:0] modifier = '0;
    logic signed [31:0] read_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] next_pc;
    logic [8:0] base_pointer;
    logic [9:0] stack_pointer;
    logic write_valid;
    logic signed [31:0] write_value;
    logic halted;
    logic [2:0] status;

    instr_t pending_instr[$];
    vm_state_t expected_state[$];
    int mismatches = 0;
    int cycle_count = 0;
    int hold_cycles = 0;

    // shadow machine state
    word_t mem_img[MEM_DEPTH];
    pc_t pc_q;
    longint bp_q, sp_q;
    bit stop_q;
    logic [2:0] stat_q;

    stack_machine_instruction_executor i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .level(level), .modifier(modifier), .read_value(read_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .next_pc(next_pc), .base_pointer(base_pointer), .stack_pointer(stack_pointer),
        .write_valid(write_valid), .write_value(write_value),
        .halted(halted), .status(status)
    );

    always #5 clk = ~clk;

    function automatic bit addr_ok(longint a);
        return a >= 0 && a < MEM_DEPTH;
    endfunction

    function automatic bit word_to_addr(word_t v, output longint a);
        a = 0;
        if (v[DATA_WIDTH-1] || v >= MEM_DEPTH)
            return 0;
        a = v;
        return 1;
    endfunction

    function automatic bit walk_links(longint start, int levels, output longint a);
        a = start;
        if (!addr_ok(a))
            return 0;
        for (int i = 0; i < levels; i++)
            if (!word_to_addr(mem_img[a], a))
                return 0;
        return 1;
    endfunction

    function automatic void set_stack_top(logic [8:0] top);
        bp_q = top;
        sp_q = longint'(top) + 1;
    endfunction

    // executes one instruction; commit=0 only reports the outcome
    function automatic logic [2:0] exec_instr(instr_t it, bit commit, output vm_state_t r);
        logic [2:0] fault;
        bit halt;
        pc_t npc;
        longint nb, ns, t, a, m;
        word_t x, y, rr;
        int nw;
        longint wa[3];
        word_t wd[3];
        bit wv;
        word_t wval;
        fault = ST_OK;
        halt = 0;
        nw = 0;
        wv = 0;
        wval = '0;
        t = 0;
        if (!stop_q) begin
            npc = pc_q + pc_t'(INSTR_WORDS);
            nb = bp_q;
            ns = sp_q;
            m = longint'($signed(it.modifier));
            case (it.cmd)
                OP_LIT: begin
                    if (!addr_ok(ns - 1)) fault = ST_RANGE;
                    else begin
                        ns--;
                        wa[0] = ns; wd[0] = it.modifier; nw = 1;
                    end
                end
                OP_OPR: begin
                    if (m == OPR_RET) begin
                        if (!addr_ok(nb - 1) || !addr_ok(nb - 2) ||
                            !word_to_addr(mem_img[nb - 1], t))
                            fault = ST_RANGE;
                        else begin
                            npc = mem_img[nb - 2][PC_WIDTH-1:0];
                            ns = nb + 1;
                            nb = t;
                        end
                    end else if (m == OPR_ODD) begin
                        if (!addr_ok(ns)) fault = ST_RANGE;
                        else begin
                            wa[0] = ns; wd[0] = word_t'(mem_img[ns][0]); nw = 1;
                        end
                    end else if (m > 0 && m < OPR_ODD) begin
                        if (!addr_ok(ns) || !addr_ok(ns + 1)) fault = ST_RANGE;
                        else begin
                            x = mem_img[ns + 1];
                            y = mem_img[ns];
                            rr = '0;
                            case (m)
                                1: rr = x + y;
                                2: rr = x - y;
                                3: rr = x * y;
                                OPR_DIV: begin
                                    if (y == '0) fault = ST_DIV0;
                                    else if (x == {1'b1, {(DATA_WIDTH-1){1'b0}}} && y == '1)
                                        rr = x;
                                    else
                                        rr = $signed(x) / $signed(y);
                                end
                                5: rr = word_t'(x == y);
                                6: rr = word_t'(x != y);
                                7: rr = word_t'($signed(x) < $signed(y));
                                8: rr = word_t'($signed(x) <= $signed(y));
                                9: rr = word_t'($signed(x) > $signed(y));
                                default: rr = word_t'($signed(x) >= $signed(y));
                            endcase
                            if (fault == ST_OK) begin
                                wa[0] = ns + 1; wd[0] = rr; nw = 1;
                                ns++;
                            end
                        end
                    end else
                        fault = ST_BADOPR;
                end
                OP_LOD: begin
                    if (!walk_links(nb, it.level, t) || !addr_ok(t - m) || !addr_ok(ns - 1))
                        fault = ST_RANGE;
                    else begin
                        ns--;
                        wa[0] = ns; wd[0] = mem_img[t - m]; nw = 1;
                    end
                end
                OP_STO: begin
                    if (!walk_links(nb, it.level, t) || !addr_ok(t - m) || !addr_ok(ns))
                        fault = ST_RANGE;
                    else begin
                        wa[0] = t - m; wd[0] = mem_img[ns]; nw = 1;
                        ns++;
                    end
                end
                OP_CAL: begin
                    if (!walk_links(nb, it.level, t) || !addr_ok(ns - 1) || !addr_ok(ns - 3))
                        fault = ST_RANGE;
                    else begin
                        wa[0] = ns - 1; wd[0] = word_t'(t);
                        wa[1] = ns - 2; wd[1] = word_t'(nb);
                        wa[2] = ns - 3; wd[2] = word_t'(npc);
                        nw = 3;
                        nb = ns - 1;
                        npc = it.modifier[PC_WIDTH-1:0];
                    end
                end
                OP_INC: begin
                    a = ns - m;
                    if (a < 0 || a > MEM_DEPTH) fault = ST_RANGE;
                    else ns = a;
                end
                OP_JMP: npc = it.modifier[PC_WIDTH-1:0];
                OP_JPC: begin
                    if (!addr_ok(ns)) fault = ST_RANGE;
                    else begin
                        if (mem_img[ns] == '0) npc = it.modifier[PC_WIDTH-1:0];
                        ns++;
                    end
                end
                OP_SYS: begin
                    if (m == SYS_WRITE) begin
                        if (!addr_ok(ns)) fault = ST_RANGE;
                        else begin
                            wv = 1; wval = mem_img[ns];
                            ns++;
                        end
                    end else if (m == SYS_READ) begin
                        if (!addr_ok(ns - 1)) fault = ST_RANGE;
                        else begin
                            ns--;
                            wa[0] = ns; wd[0] = it.read_value; nw = 1;
                        end
                    end else if (m == SYS_HALT)
                        halt = 1;
                end
                default: fault = ST_BADOP;
            endcase
            if (commit) begin
                if (fault != ST_OK) begin
                    stop_q = 1;
                    stat_q = fault;
                end else begin
                    for (int i = 0; i < nw; i++)
                        mem_img[wa[i]] = wd[i];
                    pc_q = npc;
                    bp_q = nb;
                    sp_q = ns;
                    if (halt) begin
                        stop_q = 1;
                        stat_q = ST_HALT;
                    end
                end
            end
        end
        r.next_pc = pc_q;
        r.base_pointer = bp_q[8:0];
        r.stack_pointer = sp_q[9:0];
        r.write_valid = wv && fault == ST_OK;
        r.write_value = r.write_valid ? wval : '0;
        r.halted = stop_q;
        r.status = stat_q;
        return (fault == ST_OK && halt) ? ST_HALT : fault;
    endfunction

    function automatic logic [31:0] small_val(int lo, int hi);
        return 32'($urandom_range(hi - lo)) + 32'(lo);
    endfunction

    function automatic instr_t rand_instr();
        instr_t it;
        int sel;
        sel = $urandom_range(11);
        it.cmd = (sel >= 9) ? OP_LIT : 4'(sel + 1);
        it.level = ($urandom_range(9) < 7) ? 4'($urandom_range(2)) : 4'($urandom);
        it.read_value = $urandom;
        case (it.cmd)
            OP_LIT: it.modifier = $urandom_range(1) ? $urandom : small_val(-3, 3);
            OP_OPR: it.modifier = $urandom_range(OPR_ODD);
            OP_LOD, OP_STO: it.modifier = small_val(-8, 8);
            OP_INC: it.modifier = small_val(-4, 6);
            OP_SYS: it.modifier = ($urandom_range(7) == 0) ? $urandom : small_val(1, 2);
            default: it.modifier = $urandom;
        endcase
        return it;
    endfunction

    task automatic queue_instr(instr_t it);
        vm_state_t r;
        void'(exec_instr(it, 1, r));
        pending_instr.push_back(it);
        expected_state.push_back(r);
    endtask

    // draw until an instruction runs cleanly (at most 60 tries, then a JMP), so the machine keeps going
    task automatic queue_clean_random();
        instr_t it;
        vm_state_t r;
        for (int k = 0; k < 60; k++) begin
            it = rand_instr();
            if (exec_instr(it, 0, r) == ST_OK) break;
            it.cmd = OP_JMP;
        end
        queue_instr(it);
    endtask

    task automatic queue_if_clean(logic [3:0] c, logic [3:0] l, logic [31:0] m);
        instr_t it;
        vm_state_t r;
        it.cmd = c;
        it.level = l;
        it.modifier = m;
        it.read_value = $urandom;
        if (exec_instr(it, 0, r) == ST_OK)
            queue_instr(it);
    endtask

    task automatic wait_drained();
        while (pending_instr.size() != 0 || expected_state.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_stack_top(logic [8:0] top);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= top;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_stack_top(top);
    endtask

    task automatic queue_terminal();
        instr_t it;
        it.level = '0;
        it.read_value = $urandom;
        case ($urandom_range(4))
            0: begin it.cmd = OP_SYS; it.modifier = SYS_HALT; end
            1: begin
                it.cmd = $urandom_range(1) ? 4'd0 : 4'($urandom_range(10, 15));
                it.modifier = $urandom;
            end
            2: begin it.cmd = OP_OPR; it.modifier = $urandom_range(1) ? 32'd12 : -32'sd1; end
            3: begin
                queue_if_clean(OP_LIT, 4'd5, 32'd0);
                it.cmd = OP_OPR;
                it.modifier = OPR_DIV;
            end
            default: begin it.cmd = OP_INC; it.modifier = 32'h7fffffff; end
        endcase
        queue_instr(it);
        // stopped machine ignores these
        repeat (5) queue_instr(rand_instr());
    endtask

    initial begin
        logic [8:0] tops[6];
        logic [31:0] y;
        tops = '{9'd0, 9'd510, 9'd499, 9'($urandom_range(510)), 9'($urandom_range(254) * 2 + 1),
                 9'd1};
        foreach (mem_img[i]) mem_img[i] = '0;
        pc_q = '0;
        stop_q = 0;
        stat_q = ST_OK;
        set_stack_top(RESET_TOP);

        // directed: value extremes, every OPR operation, call/return, pc wrap
        queue_if_clean(OP_LIT, 4'd0, 32'h80000000);
        for (int op = 1; op <= 10; op++) begin
            y = (op == 1) ? 32'h7fffffff : (op == 2) ? 32'hffffffff : $urandom;
            queue_if_clean(OP_LIT, 4'd0, y);
            queue_if_clean(OP_OPR, 4'd0, (op == 1) ? OPR_DIV : (op == OPR_DIV) ? 32'd1 : op);
        end
        queue_if_clean(OP_OPR, 4'd0, OPR_ODD);
        queue_if_clean(OP_SYS, 4'd0, SYS_WRITE);
        queue_if_clean(OP_SYS, 4'hf, 32'd77);
        queue_if_clean(OP_CAL, 4'd0, 32'h00012345);
        queue_if_clean(OP_INC, 4'd0, 32'd3);
        queue_if_clean(OP_OPR, 4'd0, OPR_RET);
        queue_if_clean(OP_JMP, 4'd0, 32'hfffffffe);
        queue_if_clean(OP_SYS, 4'd0, SYS_READ);
        queue_if_clean(OP_JPC, 4'd0, 32'h00001000);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                wait_drained();
                write_stack_top(tops[ph - 1]);
            end
            repeat (260) queue_clean_random();
        end
        queue_terminal();

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // quiet window with no idling on either side
    function automatic bit idle_now();
        if (cycle_count > 4000 && cycle_count < 12000)
            return 0;
        return $urandom_range(99) < 6;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready) begin
            if (pending_instr.size() != 0 && !idle_now()) begin
                cmd <= pending_instr[0].cmd;
                level <= pending_instr[0].level;
                modifier <= pending_instr[0].modifier;
                read_value <= pending_instr[0].read_value;
                void'(pending_instr.pop_front());
                in_valid <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        vm_state_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_state.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result at %0t", $realtime);
                end else begin
                    e = expected_state.pop_front();
                    if (e.next_pc !== next_pc || e.base_pointer !== base_pointer ||
                        e.stack_pointer !== stack_pointer || e.write_valid !== write_valid ||
                        e.write_value !== write_value || e.halted !== halted ||
                        e.status !== status) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch at %0t: exp pc=%h bp=%0d sp=%0d wv=%b wd=%h h=%b st=%0d got pc=%h bp=%0d sp=%0d wv=%b wd=%h h=%b st=%0d",
                                     $realtime, e.next_pc, e.base_pointer, e.stack_pointer,
                                     e.write_valid, e.write_value, e.halted, e.status,
                                     next_pc, base_pointer, stack_pointer, write_valid,
                                     write_value, halted, status);
                    end
                end
            end
            // long receiver hold-off so the request side backs up
            if (cycle_count == 2500)
                hold_cycles <= 400;
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            out_ready <= (hold_cycles == 0) && !idle_now();
        end
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_ram.sv
hw/rtl/smx_div.sv
hw/rtl/stack_machine_instruction_executor.sv
hw/rtl/smx_checker.sv
verif/tb_top.sv
